/* rtl/htw_pkg.sv */
// htw_pkg: shared constants, codes and types of the hierarchical timer wheel.
// Used by htw_place and hierarchical_timer_wheel; depends on nothing.
package htw_pkg;

	localparam int MAX_TIMERS   = 64;
	localparam int LEVEL0_SLOTS = 256;
	localparam int UPPER_SLOTS  = 64;
	localparam int LEVELS       = 5;
	localparam int TICK_BITS    = 32;

	localparam int L0_SHIFT    = $clog2(LEVEL0_SLOTS);
	localparam int UP_SHIFT    = $clog2(UPPER_SLOTS);
	localparam int TOTAL_SLOTS = LEVEL0_SLOTS + (LEVELS - 1) * UPPER_SLOTS;
	localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
	localparam int ID_W        = $clog2(MAX_TIMERS);
	localparam int LINK_W      = ID_W + 1;
	localparam int PTR_W       = L0_SHIFT;
	localparam int LV_W        = $clog2(LEVELS);
	localparam int CH_W        = $clog2(LEVELS - 1);
	localparam int REP_W       = 16;

	localparam logic [LINK_W-1:0] NIL = '1;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_REARM  = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_FIRE = 2'd1;
	localparam logic [1:0] KIND_ACC  = 2'd2;
	localparam logic [1:0] KIND_REJ  = 2'd3;

	typedef logic [LINK_W-1:0]    link_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [TICK_BITS-1:0] tick_t;
	typedef logic [LEVELS-1:0][PTR_W-1:0] ptrs_t;

	typedef struct packed {
		link_t             nxt;
		link_t             prv;
		tick_t             exp;
		tick_t             per;
		logic [REP_W-1:0]  rep;
		slot_t             slot;
	} row_t;

	typedef struct packed {
		link_t head;
		link_t tail;
	} ent_t;

	localparam ent_t ENT_NIL = '{head: NIL, tail: NIL};

	typedef struct packed {
		logic  start;
		tick_t expiry;
		tick_t now;
	} place_req_t;

	typedef struct packed {
		logic  done;
		logic  ok;
		slot_t slot;
	} place_rsp_t;

	function automatic slot_t lvl_base(input logic [LV_W-1:0] lv);
		int b;
		b = (lv == '0) ? 0 : LEVEL0_SLOTS + (int'(lv) - 1) * UPPER_SLOTS;
		return slot_t'(b);
	endfunction

endpackage

/* rtl/hierarchical_timer_wheel.sv */
// hierarchical_timer_wheel: five-level timer wheel with per-slot timer lists.
// Depends on htw_pkg, htw_ram (slot and timer tables) and htw_place (slot search).
//
// Input stream (s_*): one beat is a request; s_tuser carries the mode (tick, add,
// re-arm, remove). Output stream (m_*): result beats; m_tuser carries the kind,
// m_tlast marks the final result of a request. A request gives one result; a
// tick gives one result per fired timer, or one "tick done" result if none fire.
// cfg_we/cfg_wdata load the tick counter; write only while the block is idle.
//
// The block takes one beat at a time and drops s_tready until the work is done.
// Timing is set by the table walks, one read port per table, and by the
// one-level-per-cycle slot search. A tick retires or re-inserts each fired
// timer; a tick that wraps level 0 first walks the wrapped levels, then re-places
// each timer cascaded from them.
// Results sit in one output register; when the receiver stalls, the
// sequencer holds until that register frees up, so nothing is lost.
// After reset all 512 slot-table entries are cleared, one entry per cycle;
// s_tready stays low meanwhile. All timers start unplaced.
module hierarchical_timer_wheel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // timer_id[5:0], expiry_tick[37:6], period[69:38],
	                               // repeat_count[85:70], zero fill
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // fired_id[5:0], now_tick[37:6], zero fill
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	localparam int ROW_W = $bits(htw_pkg::row_t);
	localparam int ENT_W = $bits(htw_pkg::ent_t);

	localparam logic [4:0] ST_CLR     = 5'd0;
	localparam logic [4:0] ST_IDLE    = 5'd1;
	localparam logic [4:0] ST_REQ_LD  = 5'd2;
	localparam logic [4:0] ST_U0      = 5'd3;
	localparam logic [4:0] ST_U1      = 5'd4;
	localparam logic [4:0] ST_U2      = 5'd5;
	localparam logic [4:0] ST_U3      = 5'd6;
	localparam logic [4:0] ST_U4      = 5'd7;
	localparam logic [4:0] ST_U5      = 5'd8;
	localparam logic [4:0] ST_UDONE   = 5'd9;
	localparam logic [4:0] ST_P0      = 5'd10;
	localparam logic [4:0] ST_P1      = 5'd11;
	localparam logic [4:0] ST_P2      = 5'd12;
	localparam logic [4:0] ST_P3      = 5'd13;
	localparam logic [4:0] ST_PRET    = 5'd14;
	localparam logic [4:0] ST_CAS_RD  = 5'd15;
	localparam logic [4:0] ST_CAS_TK  = 5'd16;
	localparam logic [4:0] ST_CW_NEXT = 5'd17;
	localparam logic [4:0] ST_CW      = 5'd18;
	localparam logic [4:0] ST_CW_LD   = 5'd19;
	localparam logic [4:0] ST_ADV     = 5'd20;
	localparam logic [4:0] ST_F_RD    = 5'd21;
	localparam logic [4:0] ST_F_TK    = 5'd22;
	localparam logic [4:0] ST_FW      = 5'd23;
	localparam logic [4:0] ST_F_LD    = 5'd24;
	localparam logic [4:0] ST_F_EM    = 5'd25;
	localparam logic [4:0] ST_EMIT    = 5'd26;

	localparam logic [1:0] RET_REQ = 2'd0;
	localparam logic [1:0] RET_CW  = 2'd1;
	localparam logic [1:0] RET_FW  = 2'd2;

	logic [4:0]                    st_q;
	logic [1:0]                    ret_q;
	logic [htw_pkg::SLOT_W-1:0]    clr_q;
	logic [1:0]                    mode_q;
	htw_pkg::tick_t                exp_in_q;
	htw_pkg::tick_t                per_in_q;
	logic [htw_pkg::REP_W-1:0]     rep_in_q;
	htw_pkg::row_t                 row_q;
	htw_pkg::link_t                cur_q;
	htw_pkg::link_t                nxt_q;
	htw_pkg::link_t                tail_q;
	htw_pkg::slot_t                slot_q;
	logic                          ok_q;
	logic                          any_q;
	logic [1:0]                    kind_q;
	logic [htw_pkg::LV_W-1:0]      lv_q;
	logic [htw_pkg::CH_W-1:0]      k_q;
	htw_pkg::link_t [htw_pkg::LEVELS-2:0] ch_q;
	htw_pkg::ptrs_t                ptr_q;
	htw_pkg::ptrs_t                ptr_nx;
	htw_pkg::tick_t                now_q;
	logic [htw_pkg::MAX_TIMERS-1:0] vld_q;

	logic                          m_tvalid_q;
	logic [1:0]                    m_kind_q;
	logic [htw_pkg::ID_W-1:0]      m_id_q;
	htw_pkg::tick_t                m_now_q;
	logic                          m_last_q;
	logic                          out_free;
	logic                          out_load;

	logic                          t_we;
	logic [htw_pkg::ID_W-1:0]      t_waddr;
	htw_pkg::row_t                 t_wdata;
	logic [htw_pkg::ID_W-1:0]      t_raddr;
	logic [ROW_W-1:0]              t_rraw;
	htw_pkg::row_t                 t_rdata;
	htw_pkg::row_t                 fire_row;
	logic                          s_we;
	htw_pkg::slot_t                s_waddr;
	htw_pkg::ent_t                 s_wdata;
	htw_pkg::slot_t                s_raddr;
	logic [ENT_W-1:0]              s_rraw;
	htw_pkg::ent_t                 s_rdata;

	htw_pkg::place_req_t           place_req;
	htw_pkg::place_rsp_t           place_rsp;

	logic [htw_pkg::UP_SHIFT-1:0]  cas_off;
	htw_pkg::slot_t                cas_slot;
	htw_pkg::slot_t                fire_slot;
	logic                          carry;

	assign t_rdata = t_rraw;
	assign s_rdata = s_rraw;

	htw_ram #(.WIDTH(ROW_W), .DEPTH(htw_pkg::MAX_TIMERS)) u_timer_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rraw)
	);

	htw_ram #(.WIDTH(ENT_W), .DEPTH(htw_pkg::TOTAL_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rraw)
	);

	assign place_req = '{start: (st_q == ST_P0), expiry: row_q.exp, now: now_q};

	htw_place u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (place_req),
		.ptrs   (ptr_q),
		.rsp    (place_rsp)
	);

	// next slot of the level being cascaded, wrapping at the level size
	assign cas_off   = ptr_q[lv_q][htw_pkg::UP_SHIFT-1:0] + 1'b1;
	assign cas_slot  = htw_pkg::lvl_base(lv_q) + htw_pkg::slot_t'(cas_off);
	assign fire_slot = htw_pkg::slot_t'(ptr_q[0]);

	always_comb begin
		fire_row     = t_rdata;
		fire_row.exp = t_rdata.exp + t_rdata.per;
	end

	always_comb begin
		carry = 1'b1;
		for (int l = 0; l < htw_pkg::LEVELS; l++) begin
			ptr_nx[l] = ptr_q[l];
			if (carry) begin
				if (ptr_q[l] == htw_pkg::PTR_W'((l == 0) ? htw_pkg::LEVEL0_SLOTS - 1
				                                         : htw_pkg::UPPER_SLOTS - 1)) begin
					ptr_nx[l] = '0;
				end else begin
					ptr_nx[l] = ptr_q[l] + 1'b1;
					carry     = 1'b0;
				end
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && (st_q == ST_EMIT || st_q == ST_F_EM);
	assign s_tready = (st_q == ST_IDLE);

	always_comb begin
		t_we    = 1'b0;
		t_waddr = cur_q[htw_pkg::ID_W-1:0];
		t_wdata = row_q;
		t_raddr = cur_q[htw_pkg::ID_W-1:0];
		s_we    = 1'b0;
		s_waddr = slot_q;
		s_wdata = htw_pkg::ENT_NIL;
		s_raddr = slot_q;
		case (st_q)
			ST_CLR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
			end
			ST_IDLE: t_raddr = s_tdata[htw_pkg::ID_W-1:0];
			ST_U0: t_raddr = row_q.prv[htw_pkg::ID_W-1:0];
			ST_U1: begin
				t_we        = 1'b1;
				t_waddr     = row_q.prv[htw_pkg::ID_W-1:0];
				t_wdata     = t_rdata;
				t_wdata.nxt = row_q.nxt;
			end
			ST_U2: t_raddr = row_q.nxt[htw_pkg::ID_W-1:0];
			ST_U3: begin
				t_we        = 1'b1;
				t_waddr     = row_q.nxt[htw_pkg::ID_W-1:0];
				t_wdata     = t_rdata;
				t_wdata.prv = row_q.prv;
			end
			ST_U4: s_raddr = row_q.slot;
			ST_U5: begin
				s_we         = 1'b1;
				s_waddr      = row_q.slot;
				s_wdata.head = row_q.prv[htw_pkg::ID_W] ? row_q.nxt : s_rdata.head;
				s_wdata.tail = row_q.nxt[htw_pkg::ID_W] ? row_q.prv : s_rdata.tail;
			end
			ST_P1: s_raddr = place_rsp.slot;
			ST_P2: begin
				// append at the tail of the chosen slot
				t_we         = 1'b1;
				t_wdata.prv  = s_rdata.tail;
				t_wdata.nxt  = htw_pkg::NIL;
				t_wdata.slot = slot_q;
				s_we         = 1'b1;
				s_wdata.head = s_rdata.tail[htw_pkg::ID_W] ? cur_q : s_rdata.head;
				s_wdata.tail = cur_q;
				t_raddr      = s_rdata.tail[htw_pkg::ID_W-1:0];
			end
			ST_P3: begin
				t_we        = 1'b1;
				t_waddr     = tail_q[htw_pkg::ID_W-1:0];
				t_wdata     = t_rdata;
				t_wdata.nxt = cur_q;
			end
			ST_CAS_RD: s_raddr = cas_slot;
			ST_CAS_TK: begin
				s_we    = 1'b1;
				s_waddr = cas_slot;
			end
			ST_F_RD: s_raddr = fire_slot;
			ST_F_TK: begin
				s_we    = 1'b1;
				s_waddr = fire_slot;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLR;
			clr_q      <= '0;
			ptr_q      <= '0;
			now_q      <= '0;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
			ret_q      <= RET_REQ;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				now_q <= cfg_wdata;
			end
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == htw_pkg::SLOT_W'(htw_pkg::TOTAL_SLOTS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q   <= s_tuser;
						exp_in_q <= s_tdata[37:6];
						per_in_q <= s_tdata[69:38];
						rep_in_q <= s_tdata[85:70];
						cur_q    <= {1'b0, s_tdata[htw_pkg::ID_W-1:0]};
						if (s_tuser == htw_pkg::MODE_TICK) begin
							if (ptr_q[0] == htw_pkg::PTR_W'(htw_pkg::LEVEL0_SLOTS - 1)) begin
								lv_q <= htw_pkg::LV_W'(1);
								ch_q <= '1;
								st_q <= ST_CAS_RD;
							end else begin
								st_q <= ST_ADV;
							end
						end else begin
							st_q <= ST_REQ_LD;
						end
					end
				end
				ST_REQ_LD: begin
					row_q <= t_rdata;
					if (mode_q == htw_pkg::MODE_REARM && !vld_q[cur_q[htw_pkg::ID_W-1:0]]) begin
						kind_q <= htw_pkg::KIND_REJ;
						st_q   <= ST_EMIT;
					end else begin
						st_q <= ST_U0;
					end
				end
				ST_U0: begin
					if (!vld_q[cur_q[htw_pkg::ID_W-1:0]]) begin
						st_q <= ST_UDONE;
					end else if (!row_q.prv[htw_pkg::ID_W]) begin
						st_q <= ST_U1;
					end else begin
						st_q <= ST_U2;
					end
				end
				ST_U1: st_q <= ST_U2;
				ST_U2: st_q <= row_q.nxt[htw_pkg::ID_W] ? ST_U4 : ST_U3;
				ST_U3: st_q <= ST_U4;
				ST_U4: begin
					if (row_q.prv[htw_pkg::ID_W] || row_q.nxt[htw_pkg::ID_W]) begin
						st_q <= ST_U5;
					end else begin
						st_q <= ST_UDONE;
					end
				end
				ST_U5: st_q <= ST_UDONE;
				ST_UDONE: begin
					vld_q[cur_q[htw_pkg::ID_W-1:0]] <= 1'b0;
					ret_q <= RET_REQ;
					case (mode_q)
						htw_pkg::MODE_ADD: begin
							row_q.exp <= exp_in_q;
							row_q.per <= per_in_q;
							row_q.rep <= rep_in_q;
							st_q      <= ST_P0;
						end
						htw_pkg::MODE_REARM: begin
							row_q.exp <= exp_in_q;
							st_q      <= ST_P0;
						end
						default: begin
							kind_q <= htw_pkg::KIND_ACC;
							st_q   <= ST_EMIT;
						end
					endcase
				end
				ST_P0: st_q <= ST_P1;
				ST_P1: begin
					if (place_rsp.done) begin
						if (place_rsp.ok) begin
							slot_q <= place_rsp.slot;
							st_q   <= ST_P2;
						end else begin
							ok_q <= 1'b0;
							st_q <= ST_PRET;
						end
					end
				end
				ST_P2: begin
					tail_q <= s_rdata.tail;
					ok_q   <= 1'b1;
					vld_q[cur_q[htw_pkg::ID_W-1:0]] <= 1'b1;
					st_q   <= s_rdata.tail[htw_pkg::ID_W] ? ST_PRET : ST_P3;
				end
				ST_P3: st_q <= ST_PRET;
				ST_PRET: begin
					case (ret_q)
						RET_CW: begin
							cur_q <= nxt_q;
							st_q  <= ST_CW;
						end
						RET_FW: begin
							cur_q <= nxt_q;
							st_q  <= ST_FW;
						end
						default: begin
							kind_q <= ok_q ? htw_pkg::KIND_ACC : htw_pkg::KIND_REJ;
							st_q   <= ST_EMIT;
						end
					endcase
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_kind_q   <= kind_q;
						m_id_q     <= cur_q[htw_pkg::ID_W-1:0];
						m_now_q    <= now_q;
						m_last_q   <= 1'b1;
						st_q       <= ST_IDLE;
					end
				end
				ST_CAS_RD: st_q <= ST_CAS_TK;
				ST_CAS_TK: begin
					ch_q[htw_pkg::CH_W'(lv_q - 1'b1)] <= s_rdata.head;
					// stop at the first level that does not wrap
					if (cas_off != '0 || lv_q == htw_pkg::LV_W'(htw_pkg::LEVELS - 1)) begin
						k_q  <= '0;
						st_q <= ST_CW_NEXT;
					end else begin
						lv_q <= lv_q + 1'b1;
						st_q <= ST_CAS_RD;
					end
				end
				ST_CW_NEXT: begin
					cur_q <= ch_q[k_q];
					st_q  <= ST_CW;
				end
				ST_CW: begin
					if (cur_q[htw_pkg::ID_W]) begin
						if (k_q == htw_pkg::CH_W'(htw_pkg::LEVELS - 2)) begin
							st_q <= ST_ADV;
						end else begin
							k_q  <= k_q + 1'b1;
							st_q <= ST_CW_NEXT;
						end
					end else begin
						st_q <= ST_CW_LD;
					end
				end
				ST_CW_LD: begin
					row_q <= t_rdata;
					nxt_q <= t_rdata.nxt;
					vld_q[cur_q[htw_pkg::ID_W-1:0]] <= 1'b0;
					ret_q <= RET_CW;
					st_q  <= ST_P0;
				end
				ST_ADV: begin
					ptr_q <= ptr_nx;
					now_q <= now_q + 1'b1;
					st_q  <= ST_F_RD;
				end
				ST_F_RD: st_q <= ST_F_TK;
				ST_F_TK: begin
					cur_q <= s_rdata.head;
					any_q <= 1'b0;
					st_q  <= ST_FW;
				end
				ST_FW: begin
					if (cur_q[htw_pkg::ID_W]) begin
						if (!any_q) begin
							cur_q  <= '0;
							kind_q <= htw_pkg::KIND_TICK;
							st_q   <= ST_EMIT;
						end else begin
							st_q <= ST_IDLE;
						end
					end else begin
						st_q <= ST_F_LD;
					end
				end
				ST_F_LD: begin
					row_q <= fire_row;
					nxt_q <= t_rdata.nxt;
					vld_q[cur_q[htw_pkg::ID_W-1:0]] <= 1'b0;
					st_q  <= ST_F_EM;
				end
				ST_F_EM: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_kind_q   <= htw_pkg::KIND_FIRE;
						m_id_q     <= cur_q[htw_pkg::ID_W-1:0];
						m_now_q    <= now_q;
						m_last_q   <= nxt_q[htw_pkg::ID_W];
						any_q      <= 1'b1;
						if (row_q.rep == htw_pkg::REP_W'(1)) begin
							// retire: repeats ran out
							cur_q <= nxt_q;
							st_q  <= ST_FW;
						end else begin
							if (row_q.rep != '0) begin
								row_q.rep <= row_q.rep - 1'b1;
							end
							ret_q <= RET_FW;
							st_q  <= ST_P0;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_now_q, m_id_q};
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule

/* rtl/htw_ram.sv */
// htw_ram: generic single-write, single-read RAM with registered read data.
// Self-contained; used for the slot table and the timer table.
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/htw_place.sv */
// htw_place: level search for a timer's slot, one wheel level per cycle.
// Depends on htw_pkg for level sizes, slot bases and the request/response types.
module htw_place (
	input  logic                clk,
	input  logic                arst_n,
	input  htw_pkg::place_req_t req,
	input  htw_pkg::ptrs_t      ptrs,
	output htw_pkg::place_rsp_t rsp
);

	logic                         busy_q;
	logic [htw_pkg::LV_W-1:0]     lv_q;
	htw_pkg::tick_t               d_q;
	logic                         done_q;
	logic                         ok_q;
	htw_pkg::slot_t               slot_q;

	logic [htw_pkg::PTR_W-1:0]    ptr;
	logic [htw_pkg::TICK_BITS:0]  sz;
	logic [htw_pkg::TICK_BITS:0]  sum;
	logic                         big;
	htw_pkg::tick_t               dn;
	logic [htw_pkg::PTR_W-1:0]    off;
	htw_pkg::slot_t               slot;

	always_comb begin
		ptr = ptrs[lv_q];
		sz  = (lv_q == '0) ? (htw_pkg::TICK_BITS+1)'(htw_pkg::LEVEL0_SLOTS)
		                   : (htw_pkg::TICK_BITS+1)'(htw_pkg::UPPER_SLOTS);
		big = {1'b0, d_q} >= sz;
		sum = {1'b0, d_q} - sz + (htw_pkg::TICK_BITS+1)'(ptr) + 1'b1;
		dn  = (lv_q == '0) ? htw_pkg::tick_t'(sum >> htw_pkg::L0_SHIFT)
		                   : htw_pkg::tick_t'(sum >> htw_pkg::UP_SHIFT);
		off = ptr + d_q[htw_pkg::PTR_W-1:0] + 1'b1;
		if (lv_q == '0) begin
			slot = htw_pkg::slot_t'(off);
		end else begin
			slot = htw_pkg::lvl_base(lv_q)
				+ htw_pkg::slot_t'(off[htw_pkg::UP_SHIFT-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			lv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				d_q    <= req.expiry - req.now;
				lv_q   <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (big) begin
					// carry the distance up one level
					d_q <= dn;
					if (lv_q == htw_pkg::LV_W'(htw_pkg::LEVELS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						ok_q   <= 1'b0;
					end else begin
						lv_q <= lv_q + 1'b1;
					end
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ok_q   <= 1'b1;
					slot_q <= slot;
				end
			end
		end
	end

	assign rsp = '{done: done_q, ok: ok_q, slot: slot_q};

endmodule
